[sv/mbr_pkg.sv]
// shared types and constants for the mono bitmap raster reformatter
// used by mbr_store, mbr_core and mono_bitmap_raster_reformatter; no dependencies
package mbr_pkg;

	// store geometry: one stored row per bitmap row, padded to a power-of-two stride
	localparam int MAX_STRIDE_BYTES = 128;
	localparam int MAX_ROWS         = 2040;
	localparam int STORE_DEPTH      = MAX_STRIDE_BYTES * MAX_ROWS;
	localparam int COL_W            = $clog2(MAX_STRIDE_BYTES);
	localparam int ROW_W            = 11;
	localparam int ADDR_W           = ROW_W + COL_W;

	// configuration limits
	localparam logic [6:0]  STRIDE_MIN = 7'd4;
	localparam logic [6:0]  STRIDE_MAX = 7'd124;
	localparam logic [9:0]  WIDTH_MAX  = 10'd992;
	localparam logic [10:0] ROWS_MAX   = 11'd2040;

	// reset values of the configuration registers
	localparam logic [6:0]  STRIDE_RST = 7'd4;
	localparam logic [9:0]  WIDTH_RST  = 10'd8;
	localparam logic [10:0] ROWS_RST   = 11'd8;

	localparam logic [7:0] TOP_DOT = 8'h80;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT = 3'd3;
	localparam int CFG_DATA_W = 11;

	// commands
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] pixel_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
		logic       fault;
	} out_item_t;

	typedef struct packed {
		logic [6:0]  row_stride_bytes;
		logic [9:0]  width_pixels;
		logic [10:0] image_rows;
		logic        column_layout;
		logic        ok;
	} cfg_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [7:0]        wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} mem_req_t;

endpackage

[sv/mono_bitmap_raster_reformatter.sv]
// Load transaction: one pixel byte written to the store per cycle while idle.
// Row mode fetch: one store read, result registered; a fetch is accepted only once
// the previous result is delivered. Column mode fetch: 8 store reads through the
// single read port; a refused fetch skips the store reads.
// Reset (arst_n low, asynchronous) clears counters, sequencer and registers to
// stride 4, width 8, rows 8, row mode; the pixel store is not cleared.
module mono_bitmap_raster_reformatter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  mbr_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output mbr_pkg::out_item_t                out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mbr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mbr_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import mbr_pkg::*;

	logic [6:0]  stride_q;
	logic [9:0]  width_q;
	logic [10:0] rows_q;
	logic        layout_q;
	logic        cfg_clear;
	logic        cfg_write;
	cfg_t        cfg;
	logic        stride_ok;
	logic        width_ok;
	logic        rows_ok;

	logic        res_valid;
	logic        res_ready;
	out_item_t   res;
	mem_req_t    mem_req;
	logic [7:0]  rd_data;
	logic        out_valid_q;
	out_item_t   out_q;

	// configuration registers
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign cfg_clear = cfg_write && (cfg_index == CFG_STRIDE || cfg_index == CFG_WIDTH ||
	                                 cfg_index == CFG_ROWS || cfg_index == CFG_LAYOUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= STRIDE_RST;
			width_q  <= WIDTH_RST;
			rows_q   <= ROWS_RST;
			layout_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_STRIDE: stride_q <= cfg_data[6:0];
				CFG_WIDTH:  width_q  <= cfg_data[9:0];
				CFG_ROWS:   rows_q   <= cfg_data[10:0];
				CFG_LAYOUT: layout_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// configuration range check
	assign stride_ok = (stride_q[1:0] == 2'b00) && (stride_q >= STRIDE_MIN) &&
	                   (stride_q <= STRIDE_MAX);
	assign width_ok  = (width_q != 10'd0) && (width_q <= WIDTH_MAX) &&
	                   (width_q <= {stride_q, 3'b000});
	assign rows_ok   = (rows_q != 11'd0) && (rows_q <= ROWS_MAX);

	always_comb begin
		cfg.row_stride_bytes = stride_q;
		cfg.width_pixels     = width_q;
		cfg.image_rows       = rows_q;
		cfg.column_layout    = layout_q;
		cfg.ok               = stride_ok && width_ok && rows_ok;
	end

	mbr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cfg_clear (cfg_clear),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_req   (mem_req),
		.rd_data   (rd_data)
	);

	mbr_store u_store (
		.clk     (clk),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	// output register
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[sv/mbr_store.sv]
// pixel store: one write port, one read port with registered read data
// depends on mbr_pkg for depth and address width
module mbr_store (
	input  logic              clk,
	input  mbr_pkg::mem_req_t mem_req,
	output logic [7:0]        rd_data
);
	import mbr_pkg::*;

	logic [7:0] mem_q [0:STORE_DEPTH-1];

	// write port
	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			mem_q[mem_req.wr_addr] <= mem_req.wr_data;
		end
	end

	// read port, data registered
	always_ff @(posedge clk) begin
		if (mem_req.rd_en) begin
			rd_data <= mem_q[mem_req.rd_addr];
		end
	end

endmodule

[sv/mbr_core.sv]
// load addressing, fetch sequencer and shared bit gather unit
// depends on mbr_pkg; drives the store through a mem_req_t struct
module mbr_core (
	input  logic               clk,
	input  logic               arst_n,
	input  mbr_pkg::cfg_t      cfg,
	input  logic               cfg_clear,
	input  logic               in_valid,
	output logic               in_ready,
	input  mbr_pkg::in_item_t  in_item,
	output logic               res_valid,
	input  logic               res_ready,
	output mbr_pkg::out_item_t res,
	output mbr_pkg::mem_req_t  mem_req,
	input  logic [7:0]         rd_data
);
	import mbr_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_READ  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_PUT   = 4'b1000
	} state_t;

	state_t      state_q;
	logic [10:0] lr_q;
	logic [6:0]  lc_q;
	logic        loaded_q;
	logic [10:0] major_q;
	logic [7:0]  minor_q;
	logic [2:0]  bit_q;
	logic [7:0]  acc_q;
	logic        fault_q;

	logic        rd_valid_s1;
	logic        zero_s1;
	logic [2:0]  bit_s1;
	logic [2:0]  xsel_s1;
	logic [7:0]  mask_s1;

	logic [6:0]  stride_m1;
	logic [10:0] rows_m1;
	logic [11:0] rows_p7;
	logic [8:0]  groups;
	logic [7:0]  groups_m1;
	logic [10:0] padded_m1;
	logic [9:0]  cols_m1;
	logic        minor_end;
	logic        major_end;
	logic        last;
	logic        accept;
	logic        delivered;
	logic [10:0] rd_row;
	logic [6:0]  rd_col;
	logic        rd_zero;
	logic [9:0]  base;
	logic [9:0]  rem;
	logic [7:0]  rd_mask;
	logic [10:0] y_col;

	// derived geometry
	assign stride_m1 = cfg.row_stride_bytes - 7'd1;
	assign rows_m1   = cfg.image_rows - 11'd1;
	assign rows_p7   = {1'b0, cfg.image_rows} + 12'd7;
	assign groups    = rows_p7[11:3];
	assign groups_m1 = 8'(groups - 9'd1);
	assign padded_m1 = {groups_m1, 3'b111};
	assign cols_m1   = {cfg.row_stride_bytes, 3'b000} - 10'd1;

	// fetch position: row mode walks row/byte, column mode walks column/group
	assign minor_end = cfg.column_layout ? (minor_q == groups_m1)
	                                     : (minor_q == {1'b0, stride_m1});
	assign major_end = cfg.column_layout ? (major_q == {1'b0, cols_m1})
	                                     : (major_q == padded_m1);
	assign last = minor_end && major_end;

	// read address and pixel range checks
	assign y_col = {minor_q, bit_q};
	assign base  = {minor_q[6:0], 3'b000};
	assign rem   = cfg.width_pixels - base;
	always_comb begin
		if (cfg.column_layout) begin
			rd_row  = y_col;
			rd_col  = major_q[9:3];
			rd_zero = (y_col >= cfg.image_rows) || (major_q[9:0] >= cfg.width_pixels);
		end else begin
			rd_row  = major_q;
			rd_col  = minor_q[6:0];
			rd_zero = (major_q >= cfg.image_rows) || (base >= cfg.width_pixels);
		end
		rd_mask = (rem >= 10'd8) ? 8'hff : ~(8'hff >> rem[2:0]);
	end

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_PUT);
	assign delivered = res_valid && res_ready;
	assign res.out_byte  = acc_q;
	assign res.last_byte = last && !fault_q;
	assign res.fault     = fault_q;

	// store port requests
	always_comb begin
		mem_req.wr_en   = accept && (in_item.command == CMD_LOAD) && cfg.ok && !loaded_q;
		mem_req.wr_addr = {11'(rows_m1 - lr_q), lc_q};
		mem_req.wr_data = ~in_item.pixel_byte;
		mem_req.rd_en   = (state_q == S_READ);
		mem_req.rd_addr = {rd_row, rd_col};
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lr_q        <= '0;
			lc_q        <= '0;
			loaded_q    <= 1'b0;
			major_q     <= '0;
			minor_q     <= '0;
			bit_q       <= '0;
			fault_q     <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else if (cfg_clear) begin
			state_q     <= S_IDLE;
			lr_q        <= '0;
			lc_q        <= '0;
			loaded_q    <= 1'b0;
			major_q     <= '0;
			minor_q     <= '0;
			bit_q       <= '0;
			fault_q     <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= mem_req.rd_en;
			// load side: bottom row arrives first
			if (mem_req.wr_en) begin
				if (lc_q == stride_m1) begin
					lc_q <= '0;
					lr_q <= lr_q + 11'd1;
					if (lr_q == rows_m1) begin
						loaded_q <= 1'b1;
					end
				end else begin
					lc_q <= lc_q + 7'd1;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (accept && in_item.command == CMD_FETCH) begin
						bit_q <= '0;
						if (!cfg.ok || !loaded_q) begin
							fault_q <= 1'b1;
							state_q <= S_PUT;
						end else begin
							fault_q <= 1'b0;
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					bit_q <= bit_q + 3'd1;
					if (!cfg.column_layout || bit_q == 3'd7) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_PUT;
				end
				S_PUT: begin
					if (delivered) begin
						state_q <= S_IDLE;
						if (!fault_q) begin
							if (last) begin
								lr_q     <= '0;
								lc_q     <= '0;
								loaded_q <= 1'b0;
								major_q  <= '0;
								minor_q  <= '0;
							end else if (minor_end) begin
								minor_q <= '0;
								major_q <= major_q + 11'd1;
							end else begin
								minor_q <= minor_q + 8'd1;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// read tags, one stage behind the store address
	always_ff @(posedge clk) begin
		zero_s1 <= rd_zero;
		bit_s1  <= bit_q;
		xsel_s1 <= major_q[2:0];
		mask_s1 <= rd_mask;
	end

	// gather unit: merge one returned byte per cycle into the result
	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q <= '0;
		end else if (rd_valid_s1) begin
			if (cfg.column_layout) begin
				if (!zero_s1 && rd_data[3'd7 - xsel_s1]) begin
					acc_q <= acc_q | (TOP_DOT >> bit_s1);
				end
			end else begin
				acc_q <= zero_s1 ? 8'h00 : (rd_data & mask_s1);
			end
		end
	end

`ifndef SYNTH
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> state_q == S_IDLE)
		else $error("store written outside idle");

	a_good_needs_load: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.fault) |-> loaded_q)
		else $error("byte given from an image not fully loaded");

	a_bit_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ && cfg.column_layout && bit_q != 3'd7 && !cfg_clear)
		|=> (state_q == S_READ && bit_q == $past(bit_q) + 3'd1))
		else $error("column gather skipped a row");

	a_last_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.last_byte) |-> !res.fault)
		else $error("last byte flagged as fault");
`endif

endmodule

[verif/tb_mono_bitmap_raster_reformatter.sv]
// testbench for mono_bitmap_raster_reformatter: loads 1-bit bitmaps, fetches row and column
// rasters and checks every output transaction against a predictor kept in this file
// depends on mbr_pkg and the mono_bitmap_raster_reformatter RTL
module tb_mono_bitmap_raster_reformatter;
	import mbr_pkg::*;

	// cycles left after the last expected byte so a column read or a load can finish
	localparam int SETTLE_CYCLES   = 24;
	localparam int HOLD_OFF_CYCLES = 400;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] value;
	} reg_write_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predicted block state: inverted top-down pixel rows, progress and registers
	bit [7:0]    pixel_mem [STORE_DEPTH];
	int unsigned bytes_loaded  = 0;
	int unsigned bytes_fetched = 0;
	logic [6:0]  stride_q      = STRIDE_RST;
	logic [9:0]  width_q       = WIDTH_RST;
	logic [10:0] rows_q        = ROWS_RST;
	logic        layout_q      = 1'b0;

	out_item_t  expected_bytes[$];
	reg_write_t reg_writes_pending[$];

	int send_idle_pct   = 16;
	int recv_idle_pct   = 48;
	int hold_request    = 0;
	int errors          = 0;
	int bytes_checked   = 0;
	int images_done     = 0;
	int refused_fetches = 0;
	int reg_writes_done = 0;

	mono_bitmap_raster_reformatter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock, period 8
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// geometry legality as the block judges it
	function automatic bit geometry_ok();
		if (stride_q[1:0] != 2'b00 || stride_q < STRIDE_MIN || stride_q > STRIDE_MAX)
			return 1'b0;
		if (width_q == 10'd0 || width_q > WIDTH_MAX || int'(width_q) > int'(stride_q) * 8)
			return 1'b0;
		if (rows_q == 11'd0 || rows_q > ROWS_MAX)
			return 1'b0;
		return 1'b1;
	endfunction

	function automatic int unsigned padded_rows();
		return (int'(rows_q) + 7) & ~7;
	endfunction

	function automatic int unsigned load_len();
		return int'(stride_q) * int'(rows_q);
	endfunction

	function automatic int unsigned image_len();
		return int'(stride_q) * padded_rows();
	endfunction

	// k-th byte of the row raster, pixels past the width cleared
	function automatic logic [7:0] row_raster_byte(input int unsigned k);
		int unsigned row;
		int unsigned col;
		int unsigned lead;
		logic [7:0]  keep;
		row  = k / stride_q;
		col  = k % stride_q;
		lead = col * 8;
		if (row >= rows_q || lead >= width_q)
			return 8'h00;
		if (width_q - lead >= 8)
			keep = 8'hff;
		else
			keep = 8'hff << (8 - (width_q - lead));
		return pixel_mem[row * MAX_STRIDE_BYTES + col] & keep;
	endfunction

	// k-th 8-dot vertical byte, column by column, top dot in bit 7
	function automatic logic [7:0] column_raster_byte(input int unsigned k);
		int unsigned groups;
		int unsigned x;
		int unsigned g;
		int unsigned y;
		int          b;
		logic [7:0]  dots;
		groups = padded_rows() / 8;
		x      = k / groups;
		g      = k % groups;
		dots   = 8'h00;
		if (x >= width_q)
			return dots;
		for (b = 0; b < 8; b++) begin
			y = g * 8 + b;
			if (y < rows_q && (pixel_mem[y * MAX_STRIDE_BYTES + x / 8] & (TOP_DOT >> (x % 8))) != 0)
				dots = dots | (TOP_DOT >> b);
		end
		return dots;
	endfunction

	// advance the predictor by one accepted input transaction
	function automatic void reformat_step(input in_item_t item, output bit gives,
			output out_item_t res);
		int unsigned r;
		int unsigned c;
		bit          ok;
		ok            = geometry_ok();
		gives         = 1'b0;
		res.out_byte  = 8'h00;
		res.last_byte = 1'b0;
		res.fault     = 1'b1;
		if (item.command == CMD_LOAD) begin
			if (ok && bytes_loaded < load_len()) begin
				r = bytes_loaded / stride_q;
				c = bytes_loaded % stride_q;
				pixel_mem[(rows_q - 1 - r) * MAX_STRIDE_BYTES + c] = ~item.pixel_byte;
				bytes_loaded++;
			end
			return;
		end
		gives = 1'b1;
		if (!ok || bytes_loaded < load_len() || bytes_fetched >= image_len())
			return;
		res.out_byte = layout_q ? column_raster_byte(bytes_fetched) : row_raster_byte(bytes_fetched);
		res.fault    = 1'b0;
		bytes_fetched++;
		if (bytes_fetched >= image_len()) begin
			res.last_byte = 1'b1;
			bytes_loaded  = 0;
			bytes_fetched = 0;
		end
	endfunction

	// register write; any real register aborts the current image
	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_STRIDE: stride_q = val[6:0];
			CFG_WIDTH:  width_q  = val[9:0];
			CFG_ROWS:   rows_q   = val[10:0];
			CFG_LAYOUT: layout_q = val[0];
			default:    return;
		endcase
		bytes_loaded  = 0;
		bytes_fetched = 0;
	endfunction

	function automatic logic [7:0] edge_pixel(input int i);
		case (i % 8)
			0:       return 8'h00;
			1:       return 8'hff;
			2:       return 8'h80;
			3:       return 8'h7f;
			4:       return 8'h01;
			5:       return 8'hfe;
			6:       return 8'h55;
			default: return 8'haa;
		endcase
	endfunction

	function automatic logic [7:0] random_pixel();
		logic [31:0] r;
		r = $urandom;
		case (r[31:29])
			3'd0:    return 8'h00;
			3'd1:    return 8'hff;
			default: return r[7:0];
		endcase
	endfunction

	// one input transaction; valid stays high for a back-to-back follower
	task automatic send_item(input logic cmd, input logic [7:0] pix);
		in_item_t  item;
		out_item_t res;
		bit        gives;
		item.command    = cmd;
		item.pixel_byte = pix;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_data  <= item;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		reformat_step(item, gives, res);
		if (gives)
			expected_bytes.push_back(res);
	endtask

	// stop sending and let every outstanding transaction finish
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		reg_write_t w;
		w.index = idx;
		w.value = val;
		reg_writes_pending.push_back(w);
	endtask

	// send queued register writes back to back
	task automatic flush_regs();
		reg_write_t w;
		while (reg_writes_pending.size() != 0) begin
			w = reg_writes_pending.pop_front();
			cfg_index <= w.index;
			cfg_data  <= w.value;
			cfg_valid <= 1'b1;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			apply_reg(w.index, w.value);
			reg_writes_done++;
		end
		cfg_valid <= 1'b0;
	endtask

	// write all four registers once idle; unused upper data bits are random
	task automatic set_geometry(input logic [6:0] s, input logic [9:0] w, input logic [10:0] r,
			input logic l);
		logic [31:0] noise;
		noise = $urandom;
		settle();
		queue_reg(CFG_STRIDE, {noise[3:0], s});
		queue_reg(CFG_WIDTH, {noise[4], w});
		queue_reg(CFG_ROWS, r);
		queue_reg(CFG_LAYOUT, {noise[14:5], l});
		flush_regs();
	endtask

	// loads, with stray fetches before full load when noisy
	task automatic send_loads(input int n, input bit noisy);
		int i;
		for (i = 0; i < n; i++) begin
			if (noisy && $urandom_range(15) == 0)
				send_item(CMD_FETCH, random_pixel());
			send_item(CMD_LOAD, random_pixel());
		end
	endtask

	// fetches, with stray loads after full load when noisy
	task automatic send_fetches(input int n, input bit noisy);
		int i;
		for (i = 0; i < n; i++) begin
			if (noisy && $urandom_range(15) == 0)
				send_item(CMD_LOAD, random_pixel());
			send_item(CMD_FETCH, random_pixel());
		end
	endtask

	task automatic run_full_image(input bit noisy);
		send_loads(load_len(), noisy);
		send_fetches(image_len(), noisy);
	endtask

	// reset geometry 4x8, row mode: refused fetch, edge pixels, ignored load, end of image
	task automatic test_reset_defaults();
		int i;
		send_item(CMD_FETCH, 8'h00);
		for (i = 0; i < 32; i++)
			send_item(CMD_LOAD, edge_pixel(i));
		send_item(CMD_LOAD, 8'hff);
		for (i = 0; i < 32; i++)
			send_item(CMD_FETCH, edge_pixel(i + 1));
		send_item(CMD_FETCH, 8'hff);
	endtask

	// width not on a byte boundary and height padded to eight, both layouts
	task automatic test_partial_width();
		int i;
		for (i = 0; i < 2; i++) begin
			set_geometry(7'd4, 10'd13, 11'd5, i == 0);
			send_loads(0, 1'b0);
			for (int j = 0; j < 20; j++)
				send_item(CMD_LOAD, edge_pixel(j + i));
			send_fetches(image_len(), 1'b0);
		end
	endtask

	// every kind of illegal geometry refuses fetches and ignores loads
	task automatic test_bad_config();
		int i;
		for (i = 0; i < 10; i++) begin
			case (i)
				0: set_geometry(7'd5, 10'd8, 11'd8, 1'b0);      // stride not a multiple of four
				1: set_geometry(7'd0, 10'd8, 11'd8, 1'b0);      // zero stride
				2: set_geometry(7'd127, 10'd8, 11'd8, 1'b1);    // stride past the top
				3: set_geometry(7'd4, 10'd0, 11'd8, 1'b0);      // zero width
				4: set_geometry(7'd124, 10'd993, 11'd8, 1'b1);  // width just past the top
				5: set_geometry(7'd124, 10'd1023, 11'd8, 1'b0);
				6: set_geometry(7'd4, 10'd33, 11'd8, 1'b0);     // wider than the stride
				7: set_geometry(7'd4, 10'd8, 11'd0, 1'b1);      // zero rows
				8: set_geometry(7'd4, 10'd8, 11'd2041, 1'b0);   // rows just past the top
				default: set_geometry(7'd4, 10'd8, 11'd2047, 1'b1);
			endcase
			send_item(CMD_LOAD, random_pixel());
			send_item(CMD_FETCH, random_pixel());
		end
	endtask

	// a register write drops a half-loaded and a half-fetched image
	task automatic test_abort();
		set_geometry(7'd8, 10'd64, 11'd4, 1'b0);
		send_loads(17, 1'b0);
		settle();
		queue_reg(CFG_LAYOUT, 11'd1);
		flush_regs();
		send_item(CMD_FETCH, random_pixel());
		send_loads(load_len(), 1'b0);
		send_fetches(image_len() / 2, 1'b0);
		settle();
		queue_reg(CFG_LAYOUT, 11'd0);
		flush_regs();
		send_item(CMD_FETCH, random_pixel());
		run_full_image(1'b0);
	endtask

	// writes to indexes past the register list leave the image alone
	task automatic test_unused_index();
		logic [CFG_IDX_W-1:0] idx;
		logic [31:0]          r;
		int                   half;
		set_geometry(7'd4, 10'd32, 11'd6, 1'b1);
		half = load_len() / 2;
		send_loads(half, 1'b0);
		settle();
		idx = CFG_LAYOUT;
		repeat (4) begin
			idx++;
			r = $urandom;
			queue_reg(idx, r[CFG_DATA_W-1:0]);
		end
		flush_regs();
		send_loads(load_len() - half, 1'b0);
		send_fetches(image_len(), 1'b0);
	endtask

	// widest and narrowest geometries
	task automatic test_extreme_geometry();
		set_geometry(7'd124, 10'd992, 11'd1, 1'b1);
		run_full_image(1'b1);
		set_geometry(7'd4, 10'd1, 11'd16, 1'b1);
		run_full_image(1'b0);
		set_geometry(7'd4, 10'd1, 11'd7, 1'b0);
		run_full_image(1'b0);
	endtask

	// long output stall while fetches keep coming, so the input side backs up
	task automatic test_backpressure();
		int i;
		for (i = 0; i < 2; i++) begin
			set_geometry(7'd8, 10'd64, 11'd8, i == 1);
			send_loads(load_len(), 1'b0);
			hold_request = HOLD_OFF_CYCLES;
			send_fetches(image_len(), 1'b0);
		end
	endtask

	// random geometries; mostly whole images, some abandoned ones and some illegal settings
	task automatic test_random_images(input int target);
		int   done;
		int   kind;
		int   s;
		int   w;
		int   r;
		int   cut;
		bit   noisy;
		logic cmd;
		done = 0;
		while (done < target) begin
			kind = $urandom_range(19);
			if (kind < 2) begin
				s = 4 * $urandom_range(1, 31);
				w = 8;
				r = 8;
				case ($urandom_range(3))
					0: s = s - $urandom_range(1, 3);
					1: w = $urandom_range(1) ? 0 : $urandom_range(s * 8 + 1, 1023);
					2: r = $urandom_range(1) ? 0 : $urandom_range(2041, 2047);
					default: s = 0;
				endcase
				set_geometry(7'(s), 10'(w), 11'(r), $urandom_range(1) == 1);
				repeat ($urandom_range(3, 8)) begin
					cmd = $urandom_range(1) ? CMD_FETCH : CMD_LOAD;
					send_item(cmd, random_pixel());
					done++;
				end
			end else begin
				if (kind == 2) begin
					s = 4 * $urandom_range(9, 31);
					r = $urandom_range(1, 2);
				end else begin
					s = 4 * $urandom_range(1, 4);
					r = $urandom_range(1, 24);
				end
				w = ($urandom_range(3) == 0) ? s * 8 : $urandom_range(s * 8, 1);
				set_geometry(7'(s), 10'(w), 11'(r), $urandom_range(1) == 1);
				noisy = $urandom_range(1);
				if ($urandom_range(7) == 0) begin
					// abandoned partway; the next geometry write drops it
					if ($urandom_range(1) == 1) begin
						cut = $urandom_range(0, load_len() - 1);
						send_loads(cut, noisy);
						done += cut;
					end else begin
						done += load_len();
						send_loads(load_len(), noisy);
						cut = $urandom_range(1, image_len() - 1);
						send_fetches(cut, noisy);
						done += cut;
					end
				end else begin
					done += load_len() + image_len();
					run_full_image(noisy);
				end
			end
		end
	endtask

	// output side: random stalls, plus a long hold-off on request
	initial begin : drive_out_ready
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// compare each output transaction with the oldest predicted byte
	always @(posedge clk) begin : check_output
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				errors++;
				$display("%0t: unexpected output byte %02h last_byte %0b fault %0b", $time,
					out_data.out_byte, out_data.last_byte, out_data.fault);
			end else begin
				want = expected_bytes.pop_front();
				bytes_checked++;
				if (out_data.out_byte !== want.out_byte || out_data.last_byte !== want.last_byte
						|| out_data.fault !== want.fault) begin
					errors++;
					$display("%0t: output mismatch, expected byte %02h last %0b fault %0b",
						$time, want.out_byte, want.last_byte, want.fault);
					$display("%0t:                  actual   byte %02h last %0b fault %0b",
						$time, out_data.out_byte, out_data.last_byte, out_data.fault);
				end
				if (want.last_byte)
					images_done++;
				if (want.fault)
					refused_fetches++;
			end
		end
	end

	// test sequence
	initial begin : run_tests
		int waited;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 16;
		recv_idle_pct = 48;
		test_reset_defaults();
		test_partial_width();
		test_bad_config();
		test_abort();
		test_unused_index();
		test_random_images(100);

		send_idle_pct = 48;
		recv_idle_pct = 16;
		test_extreme_geometry();
		test_random_images(60);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure();
		test_random_images(60);

		// drain with a bound, then let the pipeline go quiet
		in_valid <= 1'b0;
		waited = 0;
		while (expected_bytes.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_bytes.size() != 0) begin
			errors++;
			$display("%0t: %0d predicted output bytes never arrived", $time,
				expected_bytes.size());
		end

		$display("covered reset geometry, row and column layouts, illegal settings, aborts,");
		$display("a long output stall: %0d bytes checked, %0d images, %0d refused, %0d reg writes",
			bytes_checked, images_done, refused_fetches, reg_writes_done);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog
	initial begin : watchdog
		#(64'd32_000_000);
		$display("%0t: run timed out with %0d bytes outstanding", $time, expected_bytes.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
